@@ design/mspk_pkg.sv @@
// Shared types and constants for the MIDI serial to USB-MIDI event packer.
package mspk_pkg;

  // Default number of SysEx chunks between forced flushes (1 to 7).
  localparam int FLUSH_CHUNKS_DEF = 7;

  // Byte values with a fixed meaning.
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
  localparam logic [7:0] BYTE_SINGLE_LOW  = 8'hF4;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;

  // Top three bits of program change / channel pressure (one data byte).
  localparam logic [2:0] STATUS_ONE_DATA  = 3'b110;

  // Code index numbers.
  localparam logic [3:0] CIN_SYSEX        = 4'd4;
  localparam logic [3:0] CIN_SINGLE       = 4'd5;
  localparam logic [3:0] CIN_SYSEX_END2   = 4'd6;
  localparam logic [3:0] CIN_SYSEX_END3   = 4'd7;

  // Slot for the next data byte.
  localparam logic [1:0] PHASE_FIRST      = 2'd1;
  localparam logic [1:0] PHASE_SECOND     = 2'd2;
  localparam logic [1:0] PHASE_THIRD      = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ONE   = 3'd2,
    MODE_TWO   = 3'd3,
    MODE_SYSEX = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] midi_first;
    logic [7:0] midi_second;
    logic [7:0] midi_third;
    logic       flush;
  } out_item_t;

endpackage

@@ design/mspk_in_if.sv @@
// Valid/ready channel carrying one received serial MIDI byte per item.
interface mspk_in_if import mspk_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ design/mspk_out_if.sv @@
// Valid/ready channel carrying one USB-MIDI event packet per item.
interface mspk_out_if import mspk_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ design/midi_serial_to_usb_event_packer.sv @@
// Top level: MIDI 1.0 serial byte stream to USB-MIDI 1.0 event packet packer.
//
// Usage
//   midi_in : one serial MIDI byte per item (rx_byte).
//   pkt_out : one USB-MIDI event per item: code index (cable 0), three MIDI
//             bytes (unused trailing bytes are zero) and a flush request.
//   A byte produces zero or one event. Status bytes below F4, the first
//   bytes of a message, stray data and stray F7 produce nothing.
// Timing
//   Two register stages: input register, then result register. An event is
//   valid on pkt_out once its byte has passed the input register and the
//   result register. One byte per cycle sustained while the sink is ready.
// Reset
//   rst (synchronous) empties both stages, closes any open message, clears
//   running status and the SysEx chunk count, and puts the slot at byte 2.
// Stall
//   While pkt_out is stalled the held event stays put; one further byte
//   may sit in the input register, after which midi_in.ready drops until
//   the event is taken. Bytes that give no event never wait on the sink
//   once the result register is free.
module midi_serial_to_usb_event_packer
  import mspk_pkg::*;
#(
  parameter int FLUSH_CHUNKS = FLUSH_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mspk_in_if.sink     midi_in,
  mspk_out_if.source  pkt_out
);

  localparam logic [2:0] FlushCount = 3'(FLUSH_CHUNKS);

  // Input stage.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Result stage.
  logic       out_valid;
  out_item_t  out_item;

  // Parser state.
  logic [3:0] header_nibble, header_nibble_next;
  logic [7:0] status_byte, status_byte_next;
  logic [7:0] held_data, held_data_next;
  logic [1:0] byte_phase, byte_phase_next;
  mode_t      message_mode, message_mode_next;
  logic [2:0] chunk_count, chunk_count_next;

  logic       out_free;
  logic       advance;
  logic       emit;
  out_item_t  result;

  // Byte classes.
  logic       is_end;
  logic       is_single;
  logic       is_status;
  logic [2:0] chunk_inc;
  logic       chunk_full;

  assign out_free      = !out_valid || pkt_out.ready;
  assign advance       = s1_valid && out_free;
  assign midi_in.ready = !s1_valid || out_free;

  assign is_end     = (s1_byte == BYTE_SYSEX_END);
  assign is_single  = !is_end && (s1_byte >= BYTE_SINGLE_LOW);
  assign is_status  = s1_byte[7] && (s1_byte < BYTE_SINGLE_LOW);
  assign chunk_inc  = chunk_count + 3'd1;
  assign chunk_full = (chunk_inc >= FlushCount);

  // Next parser state.
  always_comb begin
    header_nibble_next = header_nibble;
    status_byte_next   = status_byte;
    held_data_next     = held_data;
    byte_phase_next    = byte_phase;
    message_mode_next  = message_mode;
    chunk_count_next   = chunk_count;
    if (is_end) begin
      message_mode_next = MODE_IDLE;
      if (message_mode == MODE_SYSEX) begin
        chunk_count_next = 3'd0;
        case (byte_phase)
          PHASE_FIRST: begin
            header_nibble_next = CIN_SINGLE;
            status_byte_next   = s1_byte;
            held_data_next     = 8'd0;
          end
          PHASE_SECOND: begin
            header_nibble_next = CIN_SYSEX_END2;
            held_data_next     = s1_byte;
          end
          default: begin
            header_nibble_next = CIN_SYSEX_END3;
          end
        endcase
      end
    end else if (is_single) begin
      message_mode_next  = MODE_IDLE;
      header_nibble_next = CIN_SINGLE;
      status_byte_next   = s1_byte;
      held_data_next     = 8'd0;
    end else if (is_status) begin
      byte_phase_next  = PHASE_SECOND;
      status_byte_next = s1_byte;
      if (s1_byte < BYTE_SYSEX_START) begin
        header_nibble_next = s1_byte[7:4];
        message_mode_next  = (s1_byte[7:5] == STATUS_ONE_DATA) ? MODE_ONE : MODE_TWO;
      end else if (s1_byte == BYTE_SYSEX_START) begin
        message_mode_next  = MODE_SYSEX;
        header_nibble_next = CIN_SYSEX;
      end else if (s1_byte == BYTE_SONG_POS) begin
        message_mode_next  = MODE_TWO;
        header_nibble_next = 4'(MODE_TWO);
      end else begin
        message_mode_next  = MODE_ONE;
        header_nibble_next = 4'(MODE_ONE);
      end
    end else begin
      // data byte
      case (message_mode)
        MODE_SYSEX: begin
          case (byte_phase)
            PHASE_FIRST: begin
              status_byte_next = s1_byte;
              byte_phase_next  = PHASE_SECOND;
            end
            PHASE_SECOND: begin
              held_data_next  = s1_byte;
              byte_phase_next = PHASE_THIRD;
            end
            default: begin
              byte_phase_next  = PHASE_FIRST;
              chunk_count_next = chunk_full ? 3'd0 : chunk_inc;
            end
          endcase
        end
        MODE_TWO: begin
          if (byte_phase == PHASE_SECOND) begin
            held_data_next  = s1_byte;
            byte_phase_next = PHASE_THIRD;
          end else begin
            byte_phase_next = PHASE_SECOND;
          end
        end
        MODE_ONE: begin
          held_data_next = s1_byte;
        end
        default: begin
        end
      endcase
    end
  end

  // Event for the byte in the input register.
  always_comb begin
    emit   = 1'b0;
    result = '{code_index: header_nibble, midi_first: status_byte,
               midi_second: held_data, midi_third: s1_byte, flush: 1'b1};
    if (is_end) begin
      if (message_mode == MODE_SYSEX) begin
        emit = 1'b1;
        case (byte_phase)
          PHASE_FIRST: begin
            result = '{code_index: CIN_SINGLE, midi_first: s1_byte,
                       midi_second: 8'd0, midi_third: 8'd0, flush: 1'b1};
          end
          PHASE_SECOND: begin
            result = '{code_index: CIN_SYSEX_END2, midi_first: status_byte,
                       midi_second: s1_byte, midi_third: 8'd0, flush: 1'b1};
          end
          default: begin
            result.code_index = CIN_SYSEX_END3;
          end
        endcase
      end
    end else if (is_single) begin
      emit   = 1'b1;
      result = '{code_index: CIN_SINGLE, midi_first: s1_byte,
                 midi_second: 8'd0, midi_third: 8'd0, flush: 1'b1};
    end else if (!is_status) begin
      case (message_mode)
        MODE_SYSEX: begin
          if (byte_phase != PHASE_FIRST && byte_phase != PHASE_SECOND) begin
            emit         = 1'b1;
            result.flush = chunk_full;
          end
        end
        MODE_TWO: begin
          emit = (byte_phase != PHASE_SECOND);
        end
        MODE_ONE: begin
          emit               = 1'b1;
          result.midi_second = s1_byte;
          result.midi_third  = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      header_nibble <= 4'd0;
      status_byte   <= 8'd0;
      held_data     <= 8'd0;
      byte_phase    <= PHASE_SECOND;
      message_mode  <= MODE_IDLE;
      chunk_count   <= 3'd0;
    end else begin
      if (midi_in.ready) begin
        s1_valid <= midi_in.valid;
      end
      if (out_free) begin
        out_valid <= advance && emit;
      end
      if (advance) begin
        header_nibble <= header_nibble_next;
        status_byte   <= status_byte_next;
        held_data     <= held_data_next;
        byte_phase    <= byte_phase_next;
        message_mode  <= message_mode_next;
        chunk_count   <= chunk_count_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (midi_in.ready) begin
      s1_byte <= midi_in.item.rx_byte;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  assign pkt_out.valid = out_valid;
  assign pkt_out.item  = out_item;

  // The chunk count restarts before it reaches the flush threshold.
  a_chunk_below_limit: assert property (@(posedge clk) disable iff (rst)
    chunk_count < FlushCount)
    else $error("SysEx chunk count reached flush threshold");

  // The slot code for "none" is never stored.
  a_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    byte_phase != 2'd0)
    else $error("byte slot code zero reached");

  // An open SysEx always carries the SysEx chunk header.
  a_sysex_header: assert property (@(posedge clk) disable iff (rst)
    message_mode == MODE_SYSEX |-> header_nibble == CIN_SYSEX)
    else $error("SysEx open without SysEx header");

  // Only plain SysEx chunks may go out without a flush request.
  a_flush_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.flush |-> out_item.code_index == CIN_SYSEX)
    else $error("non-chunk event without flush");

endmodule

@@ dv/tb_midi_serial_to_usb_event_packer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the MIDI serial to USB-MIDI event packer.
module tb_midi_serial_to_usb_event_packer
  import mspk_pkg::*;
();

  // Chunk count between forced flushes; the block is built with the same value.
  localparam int CHUNK_FLUSH = FLUSH_CHUNKS_DEF;
  // Cycles with no item moving on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Bytes of random stimulus in each idling phase.
  localparam int BYTES_PER_PHASE = 150;
  // Settling time at the end, well past the two-stage latency.
  localparam int DRAIN_CYCLES = 10;

  // Directed opening: stray bytes at reset, each message class, running status,
  // real-time cancelling running status, and SysEx ending in slots one and three.
  localparam int DIRECTED_LEN = 29;
  localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
    8'h00, 8'hF7,                      // stray data, stray end of SysEx
    8'h90, 8'h00, 8'h7F,               // note on, extremes of data
    8'h7F, 8'h00,                      // running status
    8'hC0, 8'h7F,                      // one data byte message
    8'hEF, 8'h01, 8'hF8, 8'h02,        // real-time mid message, then stray data
    8'hF2, 8'h03, 8'h04,               // song position
    8'hF1, 8'h05,                      // two-byte system common
    8'hF3, 8'h06,
    8'hF0, 8'h01, 8'h02, 8'hF7,        // full chunk, end lands in the first slot
    8'hF0, 8'h01, 8'hF7,               // end lands in the third slot
    8'hF4, 8'hFF                       // single bytes at the bottom and top
  };

  // Idling per phase, in percent: none, sender only, receiver only, both.
  localparam int SEND_IDLE_TAB [4] = '{0, 82, 0, 37};
  localparam int RECV_STALL_TAB [4] = '{0, 0, 82, 37};

  // Predicts the event packets from the accepted bytes and checks the packets seen.
  class midi_event_scoreboard;
    logic [3:0] cin_hold;
    logic [7:0] first_hold;
    logic [7:0] second_hold;
    logic [1:0] slot;
    mode_t      mode;
    logic [2:0] chunks;
    out_item_t  pending_events[$];
    int         errors;

    function new();
      cin_hold    = '0;
      first_hold  = '0;
      second_hold = '0;
      slot        = PHASE_SECOND;
      mode        = MODE_IDLE;
      chunks      = '0;
      errors      = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      out_item_t ev;
      bit        fire;
      bit        fl;
      fire = 1'b0;
      ev   = '0;
      if (b == BYTE_SYSEX_END) begin
        if (mode == MODE_SYSEX) begin
          mode   = MODE_IDLE;
          chunks = '0;
          fire   = 1'b1;
          case (slot)
            PHASE_FIRST: begin
              cin_hold    = CIN_SINGLE;
              first_hold  = b;
              second_hold = '0;
              ev = '{CIN_SINGLE, b, 8'h00, 8'h00, 1'b1};
            end
            PHASE_SECOND: begin
              cin_hold    = CIN_SYSEX_END2;
              second_hold = b;
              ev = '{CIN_SYSEX_END2, first_hold, b, 8'h00, 1'b1};
            end
            default: begin
              cin_hold = CIN_SYSEX_END3;
              ev = '{CIN_SYSEX_END3, first_hold, second_hold, b, 1'b1};
            end
          endcase
        end else begin
          mode = MODE_IDLE;
        end
      end else if (b >= BYTE_SINGLE_LOW) begin
        // Real-time and undefined bytes go out alone and cancel running status.
        mode        = MODE_IDLE;
        cin_hold    = CIN_SINGLE;
        first_hold  = b;
        second_hold = '0;
        fire        = 1'b1;
        ev = '{CIN_SINGLE, b, 8'h00, 8'h00, 1'b1};
      end else if (b[7]) begin
        slot       = PHASE_SECOND;
        first_hold = b;
        if (b < BYTE_SYSEX_START) begin
          cin_hold = b[7:4];
          mode = (b[7:5] == STATUS_ONE_DATA) ? MODE_ONE : MODE_TWO;
        end else begin
          if (b == BYTE_SYSEX_START) mode = MODE_SYSEX;
          else if (b == BYTE_SONG_POS) mode = MODE_TWO;
          else mode = MODE_ONE;
          cin_hold = 4'(mode);
        end
      end else begin
        case (mode)
          MODE_SYSEX: begin
            case (slot)
              PHASE_FIRST: begin
                first_hold = b;
                slot = PHASE_SECOND;
              end
              PHASE_SECOND: begin
                second_hold = b;
                slot = PHASE_THIRD;
              end
              default: begin
                slot   = PHASE_FIRST;
                chunks = chunks + 3'd1;
                fl     = (int'(chunks) >= CHUNK_FLUSH);
                if (fl) chunks = '0;
                fire = 1'b1;
                ev = '{cin_hold, first_hold, second_hold, b, fl};
              end
            endcase
          end
          MODE_TWO: begin
            if (slot == PHASE_SECOND) begin
              second_hold = b;
              slot = PHASE_THIRD;
            end else begin
              slot = PHASE_SECOND;
              fire = 1'b1;
              ev = '{cin_hold, first_hold, second_hold, b, 1'b1};
            end
          end
          MODE_ONE: begin
            second_hold = b;
            fire = 1'b1;
            ev = '{cin_hold, first_hold, b, 8'h00, 1'b1};
          end
          default: ;  // stray data, dropped
        endcase
      end
      if (fire) pending_events.push_back(ev);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_packet(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected packet %h", $time, got);
        errors++;
      end else begin
        want = pending_events.pop_front();
        compare_field("code_index", 8'(want.code_index), 8'(got.code_index));
        compare_field("midi_first", want.midi_first, got.midi_first);
        compare_field("midi_second", want.midi_second, got.midi_second);
        compare_field("midi_third", want.midi_third, got.midi_third);
        compare_field("flush", 8'(want.flush), 8'(got.flush));
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mspk_in_if  midi_in();
  mspk_out_if pkt_out();

  midi_serial_to_usb_event_packer #(
    .FLUSH_CHUNKS(CHUNK_FLUSH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .midi_in(midi_in),
    .pkt_out(pkt_out)
  );

  midi_event_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int quiet_cycles;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: ready changes on the falling edge, stalling at the phase's rate.
  always @(negedge clk) begin
    pkt_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: items are taken at the rising edge; values read here are the
  // settled ones from before the edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (midi_in.valid && midi_in.ready) sb.note_byte(midi_in.item.rx_byte);
      if (pkt_out.valid && pkt_out.ready) sb.check_packet(pkt_out.item);
      if ((midi_in.valid && midi_in.ready) || (pkt_out.valid && pkt_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: nothing has moved for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Offers one byte, idling first at the phase's rate, and returns at the
  // falling edge after it is taken. Valid is left high for a following item.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      midi_in.valid <= 1'b0;
      @(negedge clk);
    end
    midi_in.valid        <= 1'b1;
    midi_in.item.rx_byte <= b;
    do @(posedge clk); while (!midi_in.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Data byte leaning towards the extremes.
  function automatic logic [7:0] rand_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  // A byte from F4 to FF other than end of SysEx.
  function automatic logic [7:0] rand_single();
    logic [7:0] b;
    do b = 8'($urandom_range(32'hF4, 32'hFF)); while (b == BYTE_SYSEX_END);
    return b;
  endfunction

  // One random message: mostly well formed with random content, the rest
  // truncated messages and noise.
  task automatic send_random_message();
    int unsigned kind;
    int unsigned n;
    int unsigned reps;
    logic [7:0]  st;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // Channel message with a few running-status repeats.
      st   = 8'h80 + 8'($urandom_range(0, 111));
      n    = (st[7:5] == STATUS_ONE_DATA) ? 1 : 2;
      reps = $urandom_range(1, 4);
      send_byte(st);
      repeat (reps) begin
        repeat (n) send_byte(rand_data());
      end
    end else if (kind < 55) begin
      // System common, F1 to F3.
      st = 8'($urandom_range(32'hF1, 32'hF3));
      n  = (st == BYTE_SONG_POS) ? 2 : 1;
      send_byte(st);
      repeat (n) send_byte(rand_data());
    end else if (kind < 75) begin
      // SysEx; now and then long enough to pass the flush chunk count, and
      // now and then broken by a single byte from F4 to FF other than F7.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 20);
      send_byte(BYTE_SYSEX_START);
      for (int i = 0; i < int'(n); i++) begin
        if ($urandom_range(0, 49) == 0) send_byte(rand_single());
        send_byte(rand_data());
      end
      send_byte(BYTE_SYSEX_END);
    end else if (kind < 85) begin
      send_byte(rand_single());
    end else if (kind < 93) begin
      // Truncated message: status and at most one data byte, often too few.
      st = 8'h80 + 8'($urandom_range(0, 115));
      send_byte(st);
      if ($urandom_range(0, 1)) send_byte(rand_data());
    end else begin
      // Noise over the whole byte range.
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    midi_in.valid        = 1'b0;
    midi_in.item.rx_byte = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    bytes_sent           = 0;
    rst                  = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items with no idling.
    for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED[i]);

    // Random items across the idling phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE_TAB[p];
      recv_stall_pct = RECV_STALL_TAB[p];
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) send_random_message();
    end
    midi_in.valid <= 1'b0;

    // Drain: every expected packet in, then a settling time for stragglers.
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_events.size() != 0) begin
      $display("%0t: %0d expected packets never arrived", $time, sb.pending_events.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
